>>> hdl/stereo_state_variable_filter_assert.svh
// Assertion macros shared by the stereo state variable filter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef STEREO_STATE_VARIABLE_FILTER_ASSERT_SVH
`define STEREO_STATE_VARIABLE_FILTER_ASSERT_SVH

// same-cycle implication
`define SSVF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSVF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ssvf_pkg.sv
// Package for the stereo state variable filter: widths, payload and config types,
// register map, fixed-point helpers and the sequencer microcode ROM. No dependencies.
`default_nettype none

package ssvf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GUARD_BITS  = 7;
  localparam int STATE_BITS  = (SAMPLE_BITS + GUARD_BITS > 32) ? 32 : SAMPLE_BITS + GUARD_BITS;
  localparam int MEM_W       = 32;
  localparam int MEM_DEPTH   = 8;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int COEF_FRAC   = 30;
  localparam int COEF_W      = 32;
  localparam int MUL_A_W     = COEF_W + 1;
  localparam int PROD_W      = MUL_A_W + STATE_BITS;
  localparam int ACC_W       = PROD_W + 1;
  localparam int RND_W       = ACC_W - COEF_FRAC;
  localparam int WIDE_W      = ACC_W + 2;

  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_A1      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A2      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A3      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_K       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CASCADE = 3'd5;

  typedef enum logic [1:0] {
    MODE_LP    = 2'd0,
    MODE_BP    = 2'd1,
    MODE_HP    = 2'd2,
    MODE_NOTCH = 2'd3
  } mode_t;

  typedef struct packed {
    logic [30:0] a1;
    logic [30:0] a2;
    logic [30:0] a3;
    logic [31:0] k;
    mode_t       mode;
    logic        cascade;
  } cfg_t;

  localparam logic [30:0] A1_RESET = 31'h4000_0000;
  localparam logic [31:0] K_RESET  = 32'h8000_0000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } result_t;

  localparam logic signed [WIDE_W-1:0] ST_MAX  = (WIDE_W'(1) <<< (STATE_BITS - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] ST_MIN  = -ST_MAX - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] SMP_MAX = (WIDE_W'(1) <<< (SAMPLE_BITS - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] SMP_MIN = -SMP_MAX - WIDE_W'(1);
  localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

  function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [WIDE_W-1:0] v);
    logic signed [STATE_BITS-1:0] r;
    if (v > ST_MAX)      r = ST_MAX[STATE_BITS-1:0];
    else if (v < ST_MIN) r = ST_MIN[STATE_BITS-1:0];
    else                 r = v[STATE_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMP_MAX)      r = SMP_MAX[SAMPLE_BITS-1:0];
    else if (v < SMP_MIN) r = SMP_MIN[SAMPLE_BITS-1:0];
    else                  r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

  // round half up back to the state scale
  function automatic logic signed [RND_W-1:0] rnd(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = a + RND_HALF;
    return signed'(t[ACC_W-1:COEF_FRAC]);
  endfunction

  // microcode
  typedef enum logic [1:0] {MA_A1 = 2'd0, MA_A2 = 2'd1, MA_A3 = 2'd2, MA_K = 2'd3} mul_a_t;
  typedef enum logic [1:0] {MB_IC1 = 2'd0, MB_V3 = 2'd1, MB_V1 = 2'd2} mul_b_t;
  typedef enum logic [1:0] {ACC_HOLD = 2'd0, ACC_LOAD = 2'd1, ACC_ADD = 2'd2} acc_op_t;
  typedef enum logic {SEQ_NEXT = 1'b0, SEQ_END = 1'b1} seq_t;

  typedef struct packed {
    logic    rd_en;
    logic    rd_off;
    logic    ld_ic1;
    logic    ld_ic2;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    logic    ld_v1;
    logic    ld_v2;
    logic    wr_en;
    logic    wr_off;
    seq_t    seq;
  } ucw_t;

  localparam int UC_LEN    = 9;
  localparam int STEP_W    = $clog2(UC_LEN);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(UC_LEN - 1);

  localparam ucw_t UC_NOP = '{
    rd_en: 1'b0, rd_off: 1'b0, ld_ic1: 1'b0, ld_ic2: 1'b0,
    mul_a: MA_A1, mul_b: MB_IC1, acc_op: ACC_HOLD,
    ld_v1: 1'b0, ld_v2: 1'b0, wr_en: 1'b0, wr_off: 1'b0, seq: SEQ_NEXT
  };

  function automatic ucw_t ucode(input logic [STEP_W-1:0] s);
    ucw_t w;
    w = UC_NOP;
    unique case (s)
      4'd0: begin
        w.rd_en = 1'b1;
      end
      4'd1: begin
        w.rd_en  = 1'b1;
        w.rd_off = 1'b1;
        w.ld_ic1 = 1'b1;
      end
      4'd2: begin
        w.ld_ic2 = 1'b1;
        w.mul_a  = MA_A1;
        w.mul_b  = MB_IC1;
      end
      4'd3: begin
        w.mul_a  = MA_A2;
        w.mul_b  = MB_V3;
        w.acc_op = ACC_LOAD;
      end
      4'd4: begin
        w.mul_a  = MA_A2;
        w.mul_b  = MB_IC1;
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.mul_a  = MA_A3;
        w.mul_b  = MB_V3;
        w.acc_op = ACC_LOAD;
        w.ld_v1  = 1'b1;
      end
      4'd6: begin
        w.mul_a  = MA_K;
        w.mul_b  = MB_V1;
        w.acc_op = ACC_ADD;
        w.wr_en  = 1'b1;
      end
      4'd7: begin
        w.acc_op = ACC_LOAD;
        w.ld_v2  = 1'b1;
      end
      4'd8: begin
        w.wr_en  = 1'b1;
        w.wr_off = 1'b1;
        w.seq    = SEQ_END;
      end
      default: begin
        w.seq = SEQ_END;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ssvf_core.sv
// Microcoded SVF engine: step counter over the ROM in ssvf_pkg, one shared
// multiplier, accumulator and the integrator state memory. Depends on ssvf_pkg.
`default_nettype none
`include "stereo_state_variable_filter_assert.svh"

module ssvf_core (
  input  logic             clk,
  input  logic             rst,
  input  ssvf_pkg::cfg_t    cfg,
  input  logic             start,
  input  ssvf_pkg::sample_t smp,
  input  logic             hold,
  output logic             idle,
  output logic             done,
  output ssvf_pkg::result_t res
);
  import ssvf_pkg::*;

  logic                          busy;
  logic [STEP_W-1:0]             step;
  logic                          pass;
  logic                          ch;
  ucw_t                          uc;

  logic signed [STATE_BITS-1:0]  x;
  logic signed [STATE_BITS-1:0]  right_x;
  logic signed [STATE_BITS-1:0]  ic1;
  logic signed [STATE_BITS-1:0]  ic2;
  logic signed [STATE_BITS-1:0]  v3;
  logic signed [STATE_BITS-1:0]  v1;
  logic signed [STATE_BITS-1:0]  v2;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] y_left;

  logic [MEM_W-1:0]              mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]          valid;
  logic [MEM_W-1:0]              mem_q;
  logic                          mem_qv;

  logic [MEM_AW-1:0]             rd_addr;
  logic [MEM_AW-1:0]             wr_addr;
  logic signed [STATE_BITS-1:0]  rd_state;
  logic signed [MUL_A_W-1:0]     a_op;
  logic signed [STATE_BITS-1:0]  b_op;
  logic signed [RND_W-1:0]       r_acc;
  logic signed [STATE_BITS-1:0]  ic1n;
  logic signed [STATE_BITS-1:0]  ic2n;
  logic signed [WIDE_W-1:0]      y_mode;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          at_end;
  logic                          more_cascade;
  logic                          last_item;
  logic                          stall;
  logic                          run;
  logic                          wr;

  assign uc       = ucode(step);
  assign rd_addr  = {pass, ch, uc.rd_off};
  assign wr_addr  = {pass, ch, uc.wr_off};
  assign rd_state = sat_state(WIDE_W'(signed'(mem_qv ? mem_q : '0)));
  assign r_acc    = rnd(acc);
  assign ic1n     = sat_state((WIDE_W'(v1) <<< 1) - WIDE_W'(ic1));
  assign ic2n     = sat_state((WIDE_W'(v2) <<< 1) - WIDE_W'(ic2));

  always_comb begin
    unique case (uc.mul_a)
      MA_A1: a_op = signed'(MUL_A_W'(cfg.a1));
      MA_A2: a_op = signed'(MUL_A_W'(cfg.a2));
      MA_A3: a_op = signed'(MUL_A_W'(cfg.a3));
      MA_K:  a_op = signed'(MUL_A_W'(cfg.k));
    endcase
  end

  always_comb begin
    unique case (uc.mul_b)
      MB_IC1:  b_op = ic1;
      MB_V3:   b_op = v3;
      MB_V1:   b_op = v1;
      default: b_op = ic1;
    endcase
  end

  // at the last step acc holds k*v1
  always_comb begin
    unique case (cfg.mode)
      MODE_LP:    y_mode = WIDE_W'(v2);
      MODE_BP:    y_mode = WIDE_W'(r_acc);
      MODE_HP:    y_mode = WIDE_W'(x) - WIDE_W'(r_acc) - WIDE_W'(v2);
      MODE_NOTCH: y_mode = WIDE_W'(x) - WIDE_W'(r_acc);
    endcase
  end

  assign y            = sat_sample(pass ? WIDE_W'(v2) : y_mode);
  assign at_end       = busy && (uc.seq == SEQ_END);
  assign more_cascade = !pass && cfg.cascade;
  assign last_item    = at_end && !more_cascade && ch;
  assign stall        = last_item && hold;
  assign run          = busy && !stall;
  assign wr           = run && uc.wr_en;
  assign done         = last_item && !hold;
  assign idle         = !busy;
  assign res          = '{left_out: y_left, right_out: y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      pass <= 1'b0;
      ch   <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      pass <= 1'b0;
      ch   <= 1'b0;
    end else if (run) begin
      if (uc.seq == SEQ_NEXT) begin
        step <= step + STEP_W'(1);
      end else if (more_cascade) begin
        pass <= 1'b1;
        step <= '0;
      end else if (!ch) begin
        ch   <= 1'b1;
        pass <= 1'b0;
        step <= '0;
      end else begin
        busy <= 1'b0;
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x       <= STATE_BITS'(smp.left_in);
      right_x <= STATE_BITS'(smp.right_in);
    end else if (run && at_end) begin
      if (more_cascade) begin
        x <= STATE_BITS'(y);
      end else if (!ch) begin
        x      <= right_x;
        y_left <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      if (uc.ld_ic1) ic1 <= rd_state;
      if (uc.ld_ic2) begin
        ic2 <= rd_state;
        v3  <= sat_state(WIDE_W'(x) - WIDE_W'(rd_state));
      end
      if (uc.ld_v1) v1 <= sat_state(WIDE_W'(r_acc));
      if (uc.ld_v2) v2 <= sat_state(WIDE_W'(ic2) + WIDE_W'(r_acc));
      prod <= PROD_W'(a_op) * PROD_W'(b_op);
      unique case (uc.acc_op)
        ACC_HOLD: acc <= acc;
        ACC_LOAD: acc <= ACC_W'(prod);
        ACC_ADD:  acc <= acc + ACC_W'(prod);
        default:  acc <= acc;
      endcase
    end
  end

  // integrator store; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_addr] <= MEM_W'(uc.wr_off ? ic2n : ic1n);
    end
    if (run && uc.rd_en) begin
      mem_q  <= mem[rd_addr];
      mem_qv <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  `SSVF_ASSERT_NXT(a_start_clean, clk, rst, start, busy && step == '0 && !pass && !ch, "request did not start at step zero")
  `SSVF_ASSERT_IMP(a_step_range, clk, rst, busy, step <= LAST_STEP, "step counter past end of microcode")
  `SSVF_ASSERT_IMP(a_done_right, clk, rst, done, busy && ch && at_end, "result delivered before right channel finished")
  `SSVF_ASSERT_NXT(a_stall_holds, clk, rst, stall, busy && step == $past(step) && ch == $past(ch), "sequencer moved while stalled")
  `SSVF_ASSERT_NXT(a_done_idle, clk, rst, done, !busy, "sequencer still busy after result")

endmodule

`default_nettype wire

>>> hdl/stereo_state_variable_filter.sv
// Top level of the stereo state variable filter: APB register file, request
// handshake and result register around ssvf_core. Depends on ssvf_pkg and ssvf_core.
//
//   channel   signals                                   payload
//   -------   ---------------------------------------   -------------------------
//   sample    sample_valid / sample_ready               left_in, right_in
//   result    result_valid / result_ready               left_out, right_out
//   config    psel penable pwrite paddr pwdata prdata   coefficient/mode registers
//
// One request runs two 9-step microcode passes (left, then right) through the shared
// multiplier, plus a cascade pass per channel when enabled; sample_ready follows idle.
// Reset is synchronous; the eight integrator entries are cleared by valid bits at once.
// A new request is accepted while the previous result waits; the sequencer then holds
// on its final step until the result register is free.
`default_nettype none

module stereo_state_variable_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssvf_pkg::ADDR_W-1:0]       paddr,
  input  logic [ssvf_pkg::DATA_W-1:0]       pwdata,
  output logic [ssvf_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  ssvf_pkg::sample_t                 sample,
  output logic                              result_valid,
  input  logic                              result_ready,
  output ssvf_pkg::result_t                 result
);
  import ssvf_pkg::*;

  cfg_t                 cfg;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 start;
  logic                 idle;
  logic                 done;
  logic                 hold;
  result_t              res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a1      <= A1_RESET;
      cfg.a2      <= '0;
      cfg.a3      <= '0;
      cfg.k       <= K_RESET;
      cfg.mode    <= MODE_LP;
      cfg.cascade <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_A1:      cfg.a1      <= pwdata[30:0];
        REG_A2:      cfg.a2      <= pwdata[30:0];
        REG_A3:      cfg.a3      <= pwdata[30:0];
        REG_K:       cfg.k       <= pwdata[31:0];
        REG_MODE:    cfg.mode    <= mode_t'(pwdata[1:0]);
        REG_CASCADE: cfg.cascade <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_A1:      prdata = DATA_W'(cfg.a1);
      REG_A2:      prdata = DATA_W'(cfg.a2);
      REG_A3:      prdata = DATA_W'(cfg.a3);
      REG_K:       prdata = DATA_W'(cfg.k);
      REG_MODE:    prdata = DATA_W'(cfg.mode);
      REG_CASCADE: prdata = DATA_W'(cfg.cascade);
      default:     prdata = '0;
    endcase
  end

  assign sample_ready = idle;
  assign start        = sample_valid && sample_ready;
  assign hold         = result_valid && !result_ready;

  ssvf_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (start),
    .smp   (sample),
    .hold  (hold),
    .idle  (idle),
    .done  (done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire
